// File: rtl/lbbp_pkg.sv
`timescale 1ns / 1ps

package lbbp_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int PEND_W   = 7;
    localparam int PCNT_W   = 3;
    localparam int NBYTES_W = 4;
    localparam int WORD_W   = VALUE_W + BYTE_W;

    localparam logic [COUNT_W-1:0] MAX_BIT_COUNT  = 7'd64;
    localparam logic [COUNT_W-1:0] MAX_BYTE_COUNT = 7'd8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BITS     = 2'd0,
        FUNC_BYTES_LE = 2'd1,
        FUNC_BYTES_BE = 2'd2,
        FUNC_FLUSH    = 2'd3
    } func_t;

    typedef struct packed {
        logic load;
        logic shift;
    } lbbp_cmd_t;

    typedef struct packed {
        logic load_empty;
        logic final_byte;
    } lbbp_status_t;

endpackage

// File: rtl/lbbp_ctrl.sv
`timescale 1ns / 1ps

module lbbp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  lbbp_pkg::lbbp_status_t status,
    output lbbp_pkg::lbbp_cmd_t    cmd
);
    import lbbp_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.shift      = 1'b0;
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!status.load_empty)
                    begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    cmd.shift = 1'b1;
                    if (status.final_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        in_ready_next  = (state_next == ST_IDLE);
        out_valid_next = (state_next == ST_SEND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/lbbp_datapath.sv
`timescale 1ns / 1ps

module lbbp_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lbbp_pkg::lbbp_cmd_t            cmd,
    output lbbp_pkg::lbbp_status_t         status,
    input  logic [lbbp_pkg::FUNC_W-1:0]    func,
    input  logic [lbbp_pkg::VALUE_W-1:0]   value,
    input  logic [lbbp_pkg::COUNT_W-1:0]   count,
    output logic [lbbp_pkg::BYTE_W-1:0]    out_byte,
    output logic                           last,
    output logic                           bad_count
);
    import lbbp_pkg::*;

    logic [PEND_W-1:0]   pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0]   pend_cnt_reg, pend_cnt_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [NBYTES_W-1:0] left_reg, left_next;
    logic                bits_mode_reg, bits_mode_next;
    logic                bad_reg, bad_next;

    logic [VALUE_W-1:0]  mask;
    logic [WORD_W-1:0]   comb_bits;
    logic [COUNT_W-1:0]  total_bits;
    logic [COUNT_W-1:0]  be_shift;
    logic [VALUE_W-1:0]  be_up;
    logic [VALUE_W-1:0]  be_val;
    logic [VALUE_W-1:0]  byte_val;
    logic                pad;
    logic [NBYTES_W-1:0] load_nbytes;
    logic                in_bad;

    always_comb
    begin
        mask       = count[6] ? {VALUE_W{1'b1}}
                              : ((VALUE_W'(1) << count[5:0]) - VALUE_W'(1));
        comb_bits  = (WORD_W'(value & mask) << pend_cnt_reg) | WORD_W'(pend_bits_reg);
        total_bits = COUNT_W'(pend_cnt_reg) + count;
        be_shift   = {COUNT_W'(MAX_BYTE_COUNT - count)} << 3;
        be_up      = value << be_shift;
        for (int i = 0; i < VALUE_W / BYTE_W; i++)
        begin
            be_val[i*BYTE_W +: BYTE_W] = be_up[(VALUE_W/BYTE_W-1-i)*BYTE_W +: BYTE_W];
        end
        pad = (pend_cnt_reg != '0);
        byte_val = (func_t'(func) == FUNC_BYTES_BE) ? be_val : value;

        in_bad         = 1'b0;
        word_next      = word_reg;
        left_next      = left_reg;
        bits_mode_next = bits_mode_reg;
        bad_next       = bad_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        load_nbytes    = '0;

        unique case (func_t'(func))
            FUNC_BITS:
            begin
                in_bad      = (count > MAX_BIT_COUNT);
                load_nbytes = total_bits[6:3];
            end
            FUNC_BYTES_LE, FUNC_BYTES_BE:
            begin
                in_bad      = (count > MAX_BYTE_COUNT);
                load_nbytes = NBYTES_W'(count[3:0]) + NBYTES_W'(pad);
            end
            FUNC_FLUSH:
            begin
                load_nbytes = NBYTES_W'(pad);
            end
            default: load_nbytes = '0;
        endcase
        if (in_bad)
        begin
            load_nbytes = NBYTES_W'(1);
        end

        if (cmd.load)
        begin
            left_next      = load_nbytes;
            bad_next       = in_bad;
            bits_mode_next = (func_t'(func) == FUNC_BITS) && !in_bad;
            if (in_bad)
            begin
                word_next = '0;
            end
            else if (func_t'(func) == FUNC_BITS)
            begin
                word_next      = comb_bits;
                pend_bits_next = comb_bits[PEND_W-1:0];
                pend_cnt_next  = total_bits[PCNT_W-1:0];
            end
            else
            begin
                if (func_t'(func) == FUNC_FLUSH)
                begin
                    word_next = WORD_W'(pend_bits_reg);
                end
                else if (pad)
                begin
                    word_next = {byte_val, 1'b0, pend_bits_reg};
                end
                else
                begin
                    word_next = WORD_W'(byte_val);
                end
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
        end
        else if (cmd.shift)
        begin
            word_next = word_reg >> BYTE_W;
            left_next = left_reg - NBYTES_W'(1);
            if (bits_mode_reg && status.final_byte)
            begin
                pend_bits_next = word_reg[BYTE_W +: PEND_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            left_reg      <= '0;
            bits_mode_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            left_reg      <= left_next;
            bits_mode_reg <= bits_mode_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign status.load_empty = (load_nbytes == '0);
    assign status.final_byte = (left_reg == NBYTES_W'(1));

    assign out_byte  = word_reg[BYTE_W-1:0];
    assign last      = status.final_byte;
    assign bad_count = bad_reg;

endmodule

// File: rtl/lsb_first_bit_and_byte_packer_core.sv
// Each accepted item yields N = 0..9 result bytes; the first is presented in the
// cycle after the item is taken. The byte shifter sends one byte per cycle while
// out_ready is high, and the next item is taken after the last byte.
// Reset: rst_n clears the pending partial byte, its bit count and the control
// state; the block is ready for an item right after reset.
`timescale 1ns / 1ps

module lsb_first_bit_and_byte_packer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lbbp_pkg::FUNC_W-1:0]    func,
    input  logic [lbbp_pkg::VALUE_W-1:0]   value,
    input  logic [lbbp_pkg::COUNT_W-1:0]   count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lbbp_pkg::BYTE_W-1:0]    out_byte,
    output logic                           last,
    output logic                           bad_count
);
    import lbbp_pkg::*;

    lbbp_cmd_t    cmd;
    lbbp_status_t status;

    lbbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lbbp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .func      (func),
        .value     (value),
        .count     (count),
        .out_byte  (out_byte),
        .last      (last),
        .bad_count (bad_count)
    );

endmodule

// File: rtl/lbbp_checker.sv
`timescale 1ns / 1ps

module lbbp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [lbbp_pkg::BYTE_W-1:0]    out_byte,
    input logic                           last,
    input logic                           bad_count
);
    import lbbp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("result changed while stalled");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_count |-> last && (out_byte == '0))
        else $error("error result malformed");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready && !out_valid)
        else $error("not ready after last byte");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (in_ready != out_valid))
        else $error("control state inconsistent after accept");

endmodule

bind lsb_first_bit_and_byte_packer_core lbbp_checker u_lbbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .bad_count (bad_count)
);
